// ===== src/ffa_pkg.sv =====
package ffa_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 40;
  localparam int UNIT_BYTES   = 8;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [31:0] HEAP_BASE_RESET  = 32'd65536;
  localparam logic [31:0] HEAP_LIMIT_RESET = 32'd1048576;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_BADREL  = 2'd3;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] bytes;
    logic        free;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== src/ffa_table_ram.sv =====
module ffa_table_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/first_fit_block_allocator.sv =====
// First-fit heap block allocator.
// A transaction is issued by raising start while busy is low; func selects
// allocate (request_size in eight-byte units) or release (block_addr, the
// payload address). Each transaction yields exactly one result, presented on
// status, payload_addr and reused for a single cycle with done high. The
// receiver cannot stall; it must take the result in that cycle.
// Timing: a zero-size allocate or a null release answers in the cycle after
// acceptance. Otherwise the block table, held in a synchronous RAM, is read
// one entry per cycle, lowest first, until a hit or the end of the table; an
// allocate that finds no fit then goes through an append state. One item is
// handled at a time, and a new start may be given in the cycle in which done
// is high.
// Configuration: cfg_write with cfg_index 0 sets heap_base, 1 sets heap_limit;
// writes must be made only while the block is idle; the block does not enforce it.
// Reset (rst, synchronous) empties the table and the heap and restores the
// register defaults; the RAM itself is not cleared, since only entries below
// the entry count are ever read.
module first_fit_block_allocator
  import ffa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [23:0] request_size,
  input  logic [31:0] block_addr,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] payload_addr,
  output logic        reused
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_APPEND = 2'd2;

  logic [1:0]       state;
  logic [31:0]      heap_base;
  logic [31:0]      heap_limit;
  logic [31:0]      heap_used;
  logic [CNT_W-1:0] entry_count;

  // Latched transaction and precomputed sums.
  logic             op;
  logic [31:0]      need;
  logic [32:0]      total;
  logic [32:0]      start_sum;
  logic [31:0]      addr;

  // Scan pipeline: scan_idx is the next entry to read, pend marks that RAM
  // read data for entry pend_idx is present this cycle.
  logic [CNT_W-1:0] scan_idx;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;

  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  entry_t           ram_wr_data;
  logic             ram_rd_en;
  entry_t           ram_rd_data;

  logic             accept;
  logic             hit;
  logic [31:0]      rd_payload;
  logic [33:0]      used_total;
  logic [33:0]      reach;
  logic             no_space;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign rd_payload = ram_rd_data.start + 32'(HEADER_BYTES);
  assign hit = (op == FUNC_ALLOC) ? (ram_rd_data.free && (ram_rd_data.bytes >= need))
                                  : (rd_payload == addr);

  assign used_total = {2'b00, heap_used} + {1'b0, total};
  assign reach      = {1'b0, start_sum} + {1'b0, total};
  assign no_space   = (entry_count >= CNT_W'(MAX_BLOCKS))
                   || (used_total > {2'b00, heap_limit})
                   || (reach > 34'h0_FFFF_FFFF);

  assign ram_rd_en = (state == S_SCAN) && !(pend && hit) && (scan_idx < entry_count);

  // Write-back of a hit during the scan, or the new entry on append.
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = pend_idx;
    ram_wr_data = ram_rd_data;
    if (state == S_SCAN && pend && hit) begin
      if (op == FUNC_ALLOC) begin
        ram_wr_en        = 1'b1;
        ram_wr_data.free = 1'b0;
      end else if (!ram_rd_data.free) begin
        ram_wr_en        = 1'b1;
        ram_wr_data.free = 1'b1;
      end
    end else if (state == S_APPEND && !no_space) begin
      ram_wr_en         = 1'b1;
      ram_wr_addr       = entry_count[IDX_W-1:0];
      ram_wr_data.start = start_sum[31:0];
      ram_wr_data.bytes = need;
      ram_wr_data.free  = 1'b0;
    end
  end

  ffa_table_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(scan_idx[IDX_W-1:0]),
    .rd_data(ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= HEAP_BASE_RESET;
      heap_limit <= HEAP_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_HEAP_BASE:  heap_base  <= cfg_data;
        CFG_HEAP_LIMIT: heap_limit <= cfg_data;
      endcase
    end
  end

  // Payload registers of the latched transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= func;
      need      <= 32'(request_size) * 32'(UNIT_BYTES);
      total     <= 33'(32'(request_size) * 32'(UNIT_BYTES)) + 33'(HEADER_BYTES);
      start_sum <= {1'b0, heap_base} + {1'b0, heap_used};
      addr      <= block_addr;
    end
    if (ram_rd_en) begin
      pend_idx <= scan_idx[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      pend        <= 1'b0;
      scan_idx    <= '0;
      entry_count <= '0;
      heap_used   <= '0;
    end else begin
      done <= 1'b0;
      pend <= ram_rd_en;
      unique case (state)
        S_IDLE: begin
          scan_idx <= '0;
          if (accept) begin
            status       <= ST_OK;
            payload_addr <= '0;
            reused       <= 1'b0;
            if (func == FUNC_ALLOC && request_size == 24'd0) begin
              // A zero-size request fails at once and changes nothing.
              status <= ST_ZERO;
              done   <= 1'b1;
            end else if (func == FUNC_RELEASE && block_addr == 32'd0) begin
              // Releasing null is a silent success.
              done <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (pend && hit) begin
            state <= S_IDLE;
            done  <= 1'b1;
            if (op == FUNC_ALLOC) begin
              payload_addr <= rd_payload;
              reused       <= 1'b1;
            end else if (ram_rd_data.free) begin
              // The first entry with this address is already free.
              status <= ST_BADREL;
            end
          end else if (ram_rd_en) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end else if (op == FUNC_ALLOC) begin
            state <= S_APPEND;
          end else begin
            // No entry carries the address being released.
            state  <= S_IDLE;
            done   <= 1'b1;
            status <= ST_BADREL;
          end
        end
        S_APPEND: begin
          state <= S_IDLE;
          done  <= 1'b1;
          if (no_space) begin
            status <= ST_NOSPACE;
          end else begin
            payload_addr <= start_sum[31:0] + 32'(HEADER_BYTES);
            entry_count  <= entry_count + CNT_W'(1);
            heap_used    <= used_total[31:0];
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a transaction is still in progress");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("accepted transaction neither answered nor in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_BLOCKS))
    else $error("entry count exceeds table depth");

  a_scan_write_has_data: assert property (@(posedge clk) disable iff (rst)
    (ram_wr_en && state == S_SCAN) |-> (pend && !ram_rd_en))
    else $error("write-back during scan without valid read data");

  a_heap_grows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (heap_used >= $past(heap_used)))
    else $error("heap usage decreased");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ffa_pkg::*;

  // The watchdog gives up after this many cycles in which neither a request nor a
  // result changes hands. The slowest transaction scans the whole table.
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic        fn;
    logic [23:0] units;
    logic [31:0] addr;
  } request_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] payload;
    logic        reused;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        func = FUNC_ALLOC;
  logic [23:0] request_size = '0;
  logic [31:0] block_addr = '0;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_HEAP_BASE;
  logic [31:0] cfg_data = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [31:0] payload_addr;
  logic        reused;

  first_fit_block_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .request_size (request_size),
    .block_addr   (block_addr),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .status       (status),
    .payload_addr (payload_addr),
    .reused       (reused)
  );

  always #5 clk = ~clk;

  // Our own copy of the heap: the block table, its fill level, the bytes taken
  // from the heap and the two configuration registers.
  logic [31:0] blk_start [MAX_BLOCKS];
  logic [31:0] blk_bytes [MAX_BLOCKS];
  logic        blk_free  [MAX_BLOCKS];
  int          blk_count = 0;
  logic [31:0] heap_bytes_used = '0;
  logic [31:0] heap_base_reg = HEAP_BASE_RESET;
  logic [31:0] heap_limit_reg = HEAP_LIMIT_RESET;

  request_t    request_q[$];
  answer_t     answer_q[$];
  logic [31:0] granted_payloads[$];
  request_t    next_req;

  int outstanding = 0;
  int mismatch_count = 0;
  int checked_count = 0;
  int reuse_count = 0;
  int append_count = 0;
  int refused_count = 0;
  int bad_release_count = 0;
  int stall_cycles = 0;
  int gap_left = 0;
  bit item_taken = 1'b0;
  bit quiet_run = 1'b0;

  // Works out the answer to one transaction and updates the heap copy, exactly as
  // the allocator should: first fit over the table, otherwise an append at the
  // break, with the table size, the heap limit and the top of the 32-bit address
  // space all able to refuse the append. Blocks are neither split nor merged.
  function automatic answer_t allocator_answer(input logic fn, input logic [23:0] units,
                                               input logic [31:0] addr);
    answer_t     a;
    logic [31:0] need;
    logic [31:0] pay;
    logic [63:0] total;
    logic [63:0] brk;
    logic        hit;
    a.status = ST_OK;
    a.payload = '0;
    a.reused = 1'b0;
    hit = 1'b0;
    if (fn == FUNC_ALLOC) begin
      if (units == '0) begin
        a.status = ST_ZERO;
      end else begin
        need = {8'd0, units} * UNIT_BYTES;
        for (int i = 0; i < blk_count; i++) begin
          if (!hit && blk_free[i] && blk_bytes[i] >= need) begin
            hit = 1'b1;
            blk_free[i] = 1'b0;
            a.payload = blk_start[i] + HEADER_BYTES;
            a.reused = 1'b1;
          end
        end
        if (!hit) begin
          total = {32'd0, need} + HEADER_BYTES;
          brk = {32'd0, heap_base_reg} + {32'd0, heap_bytes_used};
          if (blk_count >= MAX_BLOCKS || {32'd0, heap_bytes_used} + total > {32'd0, heap_limit_reg}
              || brk + total > 64'h0000_0000_FFFF_FFFF) begin
            a.status = ST_NOSPACE;
          end else begin
            blk_start[blk_count] = brk[31:0];
            blk_bytes[blk_count] = need;
            blk_free[blk_count] = 1'b0;
            a.payload = brk[31:0] + HEADER_BYTES;
            blk_count++;
            heap_bytes_used = heap_bytes_used + total[31:0];
          end
        end
      end
    end else if (addr != '0) begin
      // With a rewritten base two entries can share a payload address; the lowest
      // one is the one that counts.
      for (int i = 0; i < blk_count; i++) begin
        pay = blk_start[i] + HEADER_BYTES;
        if (!hit && pay == addr) begin
          hit = 1'b1;
          if (blk_free[i]) a.status = ST_BADREL;
          else blk_free[i] = 1'b1;
        end
      end
      if (!hit) a.status = ST_BADREL;
    end
    return a;
  endfunction

  // Driver: requests are presented at the falling edge and held until the block
  // takes them. Between transactions it may sit idle for a random burst, during
  // which the payload ports carry junk that must be ignored.
  always @(negedge clk) begin
    if (start && !item_taken) begin
      // Still waiting for the block to accept the current transaction.
    end else if (gap_left != 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (item_taken && !quiet_run && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      gap_left <= $urandom_range(0, 15);
      func <= 1'($urandom_range(0, 1));
      request_size <= 24'($urandom);
      block_addr <= $urandom;
    end else if (request_q.size() != 0) begin
      next_req = request_q.pop_front();
      start <= 1'b1;
      func <= next_req.fn;
      request_size <= next_req.units;
      block_addr <= next_req.addr;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: at each rising edge the result on the ports (if done is high) is
  // checked against the oldest expectation, and an accepted request has its
  // answer predicted and queued. A result may come in the same cycle that the
  // next request is taken; it always belongs to the older transaction.
  always @(posedge clk) begin
    answer_t exp_ans;
    answer_t new_ans;
    item_taken = 1'b0;
    if (!rst) begin
      if (done) begin
        if (answer_q.size() == 0) begin
          $error("result with no transaction waiting: status %0d payload_addr %h reused %0d",
                 status, payload_addr, reused);
          mismatch_count++;
        end else begin
          exp_ans = answer_q.pop_front();
          outstanding--;
          checked_count++;
          if (status !== exp_ans.status) begin
            $error("status: expected %0d, got %0d", exp_ans.status, status);
            mismatch_count++;
          end
          if (payload_addr !== exp_ans.payload) begin
            $error("payload_addr: expected %h, got %h", exp_ans.payload, payload_addr);
            mismatch_count++;
          end
          if (reused !== exp_ans.reused) begin
            $error("reused: expected %0d, got %0d", exp_ans.reused, reused);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        item_taken = 1'b1;
        new_ans = allocator_answer(func, request_size, block_addr);
        answer_q.push_back(new_ans);
        if (func == FUNC_ALLOC && new_ans.status == ST_OK) begin
          if (new_ans.reused) begin
            reuse_count++;
          end else begin
            append_count++;
            granted_payloads.push_back(new_ans.payload);
          end
        end
        if (new_ans.status == ST_NOSPACE) refused_count++;
        if (new_ans.status == ST_BADREL) bad_release_count++;
      end
      if (item_taken || done) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction moved for %0d cycles, %0d still expected",
                 STALL_LIMIT, outstanding);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic queue_item(input logic fn, input logic [23:0] units, input logic [31:0] addr);
    request_t r;
    r.fn = fn;
    r.units = units;
    r.addr = addr;
    // Keep the queue short so that release addresses drawn from the granted list
    // reflect the heap as it stands.
    wait (request_q.size() < 2);
    request_q.push_back(r);
    outstanding++;
  endtask

  // Registers are only written once every transaction has produced its result.
  task automatic write_reg(input logic idx, input logic [31:0] val);
    wait (outstanding == 0);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    if (idx == CFG_HEAP_BASE) heap_base_reg = val;
    else heap_limit_reg = val;
    @(negedge clk);
    cfg_write = 1'b0;
    cfg_data = $urandom;
  endtask

  // Random traffic: mostly small allocations that can be reused and releases of
  // addresses that were really granted (double releases arise naturally), with a
  // sprinkling of zero sizes, huge sizes, null and made-up addresses.
  task automatic run_phase(input int count);
    int          pick;
    logic [23:0] units;
    logic [31:0] addr;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 19);
      if ($urandom_range(0, 99) < 55) begin
        if (pick == 0) units = '0;
        else if (pick == 1) units = 24'($urandom);
        else if (pick < 4) units = 24'($urandom_range(1, 4096));
        else units = 24'($urandom_range(1, 16));
        queue_item(FUNC_ALLOC, units, $urandom);
      end else begin
        if (pick == 0) addr = '0;
        else if (pick < 3 || granted_payloads.size() == 0) addr = $urandom;
        else begin
          addr = granted_payloads[$urandom_range(0, granted_payloads.size() - 1)];
          if (pick == 3) addr = addr + UNIT_BYTES;
        end
        queue_item(FUNC_RELEASE, 24'($urandom), addr);
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed part, register defaults first: zero size, a size far beyond the
    // heap, appends, a null release, a good release, a double release, an
    // unknown address, reuse of a freed block and reuse of a larger block.
    queue_item(FUNC_ALLOC, 24'd0, 32'd0);
    queue_item(FUNC_ALLOC, 24'hFF_FFFF, 32'hFFFF_FFFF);
    queue_item(FUNC_ALLOC, 24'd1, 32'd0);
    queue_item(FUNC_ALLOC, 24'd3, 32'd0);
    queue_item(FUNC_RELEASE, 24'hFF_FFFF, 32'd0);
    queue_item(FUNC_RELEASE, 24'd0, HEAP_BASE_RESET + HEADER_BYTES);
    queue_item(FUNC_RELEASE, 24'd0, HEAP_BASE_RESET + HEADER_BYTES);
    queue_item(FUNC_RELEASE, 24'd0, 32'hFFFF_FFFF);
    queue_item(FUNC_ALLOC, 24'd1, 32'd0);
    queue_item(FUNC_ALLOC, 24'd2, 32'd0);
    queue_item(FUNC_RELEASE, 24'd0, HEAP_BASE_RESET + HEADER_BYTES + 48);
    queue_item(FUNC_ALLOC, 24'd2, 32'd0);

    // Heap limit: one block fits exactly, the next does not. The heap usage is
    // read only once every earlier transaction has been predicted.
    wait (outstanding == 0);
    write_reg(CFG_HEAP_LIMIT, heap_bytes_used + HEADER_BYTES + UNIT_BYTES);
    queue_item(FUNC_ALLOC, 24'd1, 32'd0);
    queue_item(FUNC_ALLOC, 24'd1, 32'd0);

    // A limit of zero still lets a freed block be reused.
    write_reg(CFG_HEAP_LIMIT, 32'd0);
    queue_item(FUNC_RELEASE, 24'd0, HEAP_BASE_RESET + HEADER_BYTES);
    queue_item(FUNC_ALLOC, 24'd1, 32'd0);
    queue_item(FUNC_ALLOC, 24'd1, 32'd0);

    // Near the top of the address space: a small block fits, a larger one would
    // run past it.
    write_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
    wait (outstanding == 0);
    write_reg(CFG_HEAP_BASE, 32'hFFFF_FFFF - heap_bytes_used - 100);
    queue_item(FUNC_ALLOC, 24'd1, 32'd0);
    queue_item(FUNC_ALLOC, 24'd8, 32'd0);
    write_reg(CFG_HEAP_BASE, 32'hFFFF_FFFF);
    queue_item(FUNC_ALLOC, 24'd1, 32'd0);

    // Base moved down so that the next block lands on the first block's address:
    // releases then hit the lowest of the two matching entries.
    wait (outstanding == 0);
    write_reg(CFG_HEAP_BASE, HEAP_BASE_RESET - heap_bytes_used);
    queue_item(FUNC_ALLOC, 24'd1, 32'd0);
    queue_item(FUNC_RELEASE, 24'd0, HEAP_BASE_RESET + HEADER_BYTES);
    queue_item(FUNC_RELEASE, 24'd0, HEAP_BASE_RESET + HEADER_BYTES);
    queue_item(FUNC_ALLOC, 24'd1, 32'd0);

    // Lowest base.
    write_reg(CFG_HEAP_BASE, 32'd1);
    queue_item(FUNC_ALLOC, 24'd1, 32'd0);

    // Random phases. The first keeps the heap close to its limit, the second lets
    // the table fill up, the third sits near the top of the address space, and the
    // last runs back at the register defaults with no idle cycles at all.
    write_reg(CFG_HEAP_BASE, $urandom_range(32'h00FF_FFFF, 1));
    wait (outstanding == 0);
    write_reg(CFG_HEAP_LIMIT, heap_bytes_used + $urandom_range(4096, 512));
    run_phase(300);

    write_reg(CFG_HEAP_BASE, $urandom_range(32'hFFFF_FFFF, 1));
    write_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
    run_phase(300);

    wait (outstanding == 0);
    write_reg(CFG_HEAP_BASE, 32'hFFFF_FFFF - heap_bytes_used - $urandom_range(20000, 0));
    write_reg(CFG_HEAP_LIMIT, $urandom);
    run_phase(300);

    write_reg(CFG_HEAP_BASE, HEAP_BASE_RESET);
    write_reg(CFG_HEAP_LIMIT, HEAP_LIMIT_RESET);
    quiet_run = 1'b1;
    run_phase(400);

    // Let the last results arrive, then allow one more full table scan so that a
    // stray extra result would still be caught.
    wait (outstanding == 0);
    repeat (MAX_BLOCKS + 8) @(posedge clk);

    $display("summary: %0d transactions checked; %0d blocks appended, %0d reused",
             checked_count, append_count, reuse_count);
    $display("summary: %0d allocations refused, %0d bad releases, table ended at %0d of %0d",
             refused_count, bad_release_count, blk_count, MAX_BLOCKS);
    if (mismatch_count == 0 && answer_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
